// ===== src/rgbls_pkg.sv =====
`default_nettype none
package rgbls_pkg;

  localparam int unsigned GridRows       = 4;
  localparam int unsigned GridCols       = 4;
  localparam int unsigned RepeatsPerCell = 4;
  localparam int unsigned CellCount      = GridRows * GridCols;
  localparam int unsigned CellW          = (CellCount > 1) ? $clog2(CellCount) : 1;
  localparam int unsigned RepW           = (RepeatsPerCell > 1) ? $clog2(RepeatsPerCell) : 1;
  localparam int unsigned BitsPerCopy    = 24;
  localparam int unsigned BitPtrW        = 5;
  localparam int unsigned ColorW         = 8;
  localparam int unsigned GapW           = 16;
  localparam int unsigned QueueDepth     = 2;
  localparam int unsigned QPtrW          = 1;
  localparam int unsigned QCntW          = $clog2(QueueDepth + 1);
  localparam int unsigned AddrW          = 3;
  localparam int unsigned DataW          = 32;

  localparam logic            RegFrameGap = 1'b0;
  localparam logic [GapW-1:0] GapReset    = 16'd1;

  typedef enum logic [1:0] {
    FuncSetCell  = 2'd0,
    FuncClearAll = 2'd1,
    FuncTick     = 2'd2
  } func_e;

  typedef struct packed {
    func_e                   op;
    logic [CellW-1:0]        addr;
    logic [3*ColorW-1:0]     rgb;
  } cmd_t;

endpackage
`default_nettype wire

// ===== src/rgbls_in_if.sv =====
`default_nettype none
interface rgbls_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [1:0] row_index;
  logic [1:0] col_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, func, row_index, col_index, red, green, blue, input ready);
  modport sink (input valid, func, row_index, col_index, red, green, blue, output ready);
endinterface
`default_nettype wire

// ===== src/rgbls_out_if.sv =====
`default_nettype none
interface rgbls_out_if;
  logic valid;
  logic ready;
  logic data_bit;
  logic frame_end;

  modport source (output valid, data_bit, frame_end, input ready);
  modport sink (input valid, data_bit, frame_end, output ready);
endinterface
`default_nettype wire

// ===== src/rgbls_front.sv =====
`default_nettype none
module rgbls_front (
  rgbls_in_if.sink               item_i,
  output logic                   push_valid_o,
  input  logic                   push_ready_i,
  output rgbls_pkg::cmd_t        push_data_o
);

  logic keep;
  logic in_range;

  assign in_range = (32'(item_i.row_index) < rgbls_pkg::GridRows) &&
                    (32'(item_i.col_index) < rgbls_pkg::GridCols);

  always_comb begin
    keep = 1'b0;
    case (rgbls_pkg::func_e'(item_i.func))
      rgbls_pkg::FuncSetCell:  keep = in_range;
      rgbls_pkg::FuncClearAll: keep = 1'b1;
      rgbls_pkg::FuncTick:     keep = 1'b1;
      default:                 keep = 1'b0;
    endcase
  end

  assign push_data_o.op   = rgbls_pkg::func_e'(item_i.func);
  assign push_data_o.addr = rgbls_pkg::CellW'(32'(item_i.row_index) * rgbls_pkg::GridCols +
                                              32'(item_i.col_index));
  assign push_data_o.rgb  = {item_i.red, item_i.green, item_i.blue};

  // unused codes and out-of-range writes are taken and dropped here
  assign push_valid_o = item_i.valid && keep;
  assign item_i.ready = push_ready_i;

endmodule
`default_nettype wire

// ===== src/rgbls_queue.sv =====
`default_nettype none
module rgbls_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  rgbls_pkg::cmd_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output rgbls_pkg::cmd_t pop_data_o
);

  rgbls_pkg::cmd_t                    mem_q [rgbls_pkg::QueueDepth];
  logic [rgbls_pkg::QPtrW-1:0]        wptr_q, wptr_d;
  logic [rgbls_pkg::QPtrW-1:0]        rptr_q, rptr_d;
  logic [rgbls_pkg::QCntW-1:0]        cnt_q, cnt_d;
  logic                               push, pop;

  assign push_ready_o = (cnt_q != rgbls_pkg::QCntW'(rgbls_pkg::QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wptr_d = push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = pop ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ===== src/rgbls_back.sv =====
`default_nettype none
module rgbls_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         pop_valid_i,
  output logic                         pop_ready_o,
  input  rgbls_pkg::cmd_t              pop_data_i,
  input  logic [rgbls_pkg::GapW-1:0]   frame_gap_i,
  rgbls_out_if.source                  result_o
);

  logic [3*rgbls_pkg::ColorW-1:0] buf_q [rgbls_pkg::CellCount];
  logic [rgbls_pkg::CellCount-1:0] vld_q, vld_d;

  logic                            sending_q, sending_d;
  logic                            dirty_q, dirty_d;
  logic [rgbls_pkg::CellW-1:0]     cell_ptr_q, cell_ptr_d;
  logic [rgbls_pkg::RepW-1:0]      rep_q, rep_d;
  logic [rgbls_pkg::BitPtrW-1:0]   bit_ptr_q, bit_ptr_d;
  logic [rgbls_pkg::GapW-1:0]      gap_q, gap_d;
  logic                            out_valid_q, out_valid_d;
  logic                            out_bit_q, out_bit_d;
  logic                            out_end_q, out_end_d;

  logic                            fire, is_tick, emit, last;
  logic                            last_bit, last_rep, last_cell;
  logic [3*rgbls_pkg::ColorW-1:0]  word;
  logic [rgbls_pkg::BitPtrW-1:0]   sel;

  assign pop_ready_o = !out_valid_q || result_o.ready;
  assign fire        = pop_valid_i && pop_ready_o;
  assign is_tick     = fire && (pop_data_i.op == rgbls_pkg::FuncTick);
  assign emit        = is_tick && (sending_q || (gap_q == '0 && dirty_q));

  assign word = vld_q[cell_ptr_q] ? buf_q[cell_ptr_q] : '0;
  assign sel  = rgbls_pkg::BitPtrW'(rgbls_pkg::BitsPerCopy - 1) - bit_ptr_q;

  assign last_bit  = (bit_ptr_q == rgbls_pkg::BitPtrW'(rgbls_pkg::BitsPerCopy - 1));
  assign last_rep  = (rep_q == rgbls_pkg::RepW'(rgbls_pkg::RepeatsPerCell - 1));
  assign last_cell = (cell_ptr_q == rgbls_pkg::CellW'(rgbls_pkg::CellCount - 1));
  assign last      = last_bit && last_rep && last_cell;

  always_comb begin
    vld_d      = vld_q;
    sending_d  = sending_q;
    dirty_d    = dirty_q;
    cell_ptr_d = cell_ptr_q;
    rep_d      = rep_q;
    bit_ptr_d  = bit_ptr_q;
    gap_d      = gap_q;
    out_valid_d = out_valid_q && !result_o.ready;
    out_bit_d   = out_bit_q;
    out_end_d   = out_end_q;

    if (fire) begin
      case (pop_data_i.op)
        rgbls_pkg::FuncSetCell: begin
          vld_d[pop_data_i.addr] = 1'b1;
          dirty_d = 1'b1;
        end
        rgbls_pkg::FuncClearAll: begin
          vld_d   = '0;
          dirty_d = 1'b1;
        end
        rgbls_pkg::FuncTick: begin
          if (!sending_q) begin
            if (gap_q != '0) begin
              gap_d = gap_q - 1'b1;
            end else if (dirty_q) begin
              dirty_d   = 1'b0;
              sending_d = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end

    // pointers sit at the frame start whenever no frame is running
    if (emit) begin
      out_valid_d = 1'b1;
      out_bit_d   = word[sel];
      out_end_d   = last;
      if (last) begin
        sending_d  = 1'b0;
        cell_ptr_d = '0;
        rep_d      = '0;
        bit_ptr_d  = '0;
        gap_d      = frame_gap_i;
      end else if (!last_bit) begin
        bit_ptr_d = bit_ptr_q + 1'b1;
      end else begin
        bit_ptr_d = '0;
        if (!last_rep) begin
          rep_d = rep_q + 1'b1;
        end else begin
          rep_d      = '0;
          cell_ptr_d = cell_ptr_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      sending_q   <= 1'b0;
      dirty_q     <= 1'b1;
      cell_ptr_q  <= '0;
      rep_q       <= '0;
      bit_ptr_q   <= '0;
      gap_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      vld_q       <= vld_d;
      sending_q   <= sending_d;
      dirty_q     <= dirty_d;
      cell_ptr_q  <= cell_ptr_d;
      rep_q       <= rep_d;
      bit_ptr_q   <= bit_ptr_d;
      gap_q       <= gap_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_bit_q <= out_bit_d;
    out_end_q <= out_end_d;
    if (fire && pop_data_i.op == rgbls_pkg::FuncSetCell) begin
      buf_q[pop_data_i.addr] <= pop_data_i.rgb;
    end
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.data_bit  = out_bit_q;
  assign result_o.frame_end = out_end_q;

endmodule
`default_nettype wire

// ===== src/rgb_grid_led_serializer.sv =====
// An item is taken into a two-entry queue, executed from its head, and a resulting bit
// is loaded into the output register. Throughput: one item per cycle while the output
// is not stalled by result_o.ready, set by the single execute stage of the back end.
// Reset (async, active low): buffer reads as zero, frame marked dirty, gap register 1,
// queue and output empty.
`default_nettype none
module rgb_grid_led_serializer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  rgbls_in_if.sink                        item_i,
  rgbls_out_if.source                     result_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rgbls_pkg::AddrW-1:0]     paddr,
  input  logic [rgbls_pkg::DataW-1:0]     pwdata,
  output logic [rgbls_pkg::DataW-1:0]     prdata,
  output logic                            pready
);

  logic                          push_valid, push_ready;
  rgbls_pkg::cmd_t               push_data;
  logic                          pop_valid, pop_ready;
  rgbls_pkg::cmd_t               pop_data;
  logic [rgbls_pkg::GapW-1:0]    gap_cfg_q;
  logic                          hit;

  assign pready = 1'b1;
  assign hit    = (paddr[rgbls_pkg::AddrW-1] == rgbls_pkg::RegFrameGap);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_cfg_q <= rgbls_pkg::GapReset;
    end else if (psel && penable && pwrite && hit) begin
      gap_cfg_q <= pwdata[rgbls_pkg::GapW-1:0];
    end
  end

  assign prdata = hit ? rgbls_pkg::DataW'(gap_cfg_q) : '0;

  rgbls_front u_front (
    .item_i       (item_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  rgbls_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  rgbls_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .frame_gap_i (gap_cfg_q),
    .result_o    (result_o)
  );

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned     SettleCycles = 4;
  localparam logic [1:0]      FuncUnused   = 2'd3;
  localparam logic [rgbls_pkg::AddrW-1:0] GapAddr =
    rgbls_pkg::AddrW'({rgbls_pkg::RegFrameGap, 2'b00});
  localparam logic [rgbls_pkg::AddrW-1:0] SpareAddr = GapAddr + rgbls_pkg::AddrW'(4);

  typedef struct packed {
    logic data_bit;
    logic frame_end;
  } serial_bit_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [rgbls_pkg::AddrW-1:0]  paddr;
  logic [rgbls_pkg::DataW-1:0]  pwdata;
  logic [rgbls_pkg::DataW-1:0]  prdata;
  logic                         pready;

  rgbls_in_if  item_if ();
  rgbls_out_if res_if ();

  rgb_grid_led_serializer u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (res_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // shadow of the LED frame state
  logic [3*rgbls_pkg::ColorW-1:0] pix_mem [rgbls_pkg::CellCount];
  logic                           pending_frame;
  logic                           tx_active;
  logic [rgbls_pkg::CellW-1:0]    tx_cell;
  logic [rgbls_pkg::RepW-1:0]     tx_copy;
  logic [rgbls_pkg::BitPtrW-1:0]  tx_bit;
  logic [rgbls_pkg::GapW-1:0]     gap_left;
  logic [rgbls_pkg::GapW-1:0]     gap_cfg;
  int unsigned                    frames_sent = 0;
  serial_bit_t                    bit_q [$];
  int unsigned                    err_cnt = 0;
  bit                             fast_mode = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int unsigned draw_idle();
    return fast_mode ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic void emit_next_bit();
    serial_bit_t s;
    s.data_bit  = pix_mem[tx_cell][rgbls_pkg::BitsPerCopy - 1 - tx_bit];
    s.frame_end = (tx_cell == rgbls_pkg::CellCount - 1) &&
                  (tx_copy == rgbls_pkg::RepeatsPerCell - 1) &&
                  (tx_bit == rgbls_pkg::BitsPerCopy - 1);
    bit_q.push_back(s);
    if (s.frame_end) begin
      tx_active = 1'b0;
      tx_cell   = '0;
      tx_copy   = '0;
      tx_bit    = '0;
      gap_left  = gap_cfg;
      frames_sent++;
    end else if (tx_bit != rgbls_pkg::BitsPerCopy - 1) begin
      tx_bit++;
    end else begin
      tx_bit = '0;
      if (tx_copy != rgbls_pkg::RepeatsPerCell - 1) begin
        tx_copy++;
      end else begin
        tx_copy = '0;
        tx_cell++;
      end
    end
  endfunction

  function automatic void advance_serializer(input logic [1:0] f, input logic [1:0] r,
                                             input logic [1:0] c, input logic [7:0] rd,
                                             input logic [7:0] gr, input logic [7:0] bl);
    case (f)
      rgbls_pkg::FuncSetCell: begin
        pix_mem[r * rgbls_pkg::GridCols + c] = {rd, gr, bl};
        pending_frame = 1'b1;
      end
      rgbls_pkg::FuncClearAll: begin
        foreach (pix_mem[i]) pix_mem[i] = '0;
        pending_frame = 1'b1;
      end
      rgbls_pkg::FuncTick: begin
        if (tx_active) begin
          emit_next_bit();
        end else if (gap_left != 0) begin
          gap_left--;
        end else if (pending_frame) begin
          pending_frame = 1'b0;
          tx_active     = 1'b1;
          tx_cell       = '0;
          tx_copy       = '0;
          tx_bit        = '0;
          emit_next_bit();
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(input logic [1:0] f, input logic [1:0] r, input logic [1:0] c,
                           input logic [7:0] rd, input logic [7:0] gr, input logic [7:0] bl);
    int unsigned idle;
    idle = draw_idle();
    if (idle != 0) begin
      item_if.valid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    item_if.valid     <= 1'b1;
    item_if.func      <= f;
    item_if.row_index <= r;
    item_if.col_index <= c;
    item_if.red       <= rd;
    item_if.green     <= gr;
    item_if.blue      <= bl;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    advance_serializer(f, r, c, rd, gr, bl);
  endtask

  task automatic send_tick();
    send_item(rgbls_pkg::FuncTick, 2'($urandom), 2'($urandom), 8'($urandom),
              8'($urandom), 8'($urandom));
  endtask

  task automatic send_random(input int unsigned tick_pct);
    int unsigned roll;
    logic [1:0]  f;
    roll = $urandom_range(0, 99);
    if (roll < tick_pct) f = rgbls_pkg::FuncTick;
    else if (roll < 96) f = rgbls_pkg::FuncSetCell;
    else if (roll < 99) f = rgbls_pkg::FuncClearAll;
    else f = FuncUnused;
    send_item(f, 2'($urandom), 2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic drain_results();
    item_if.valid <= 1'b0;
    while (bit_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [rgbls_pkg::AddrW-1:0] addr,
                           input logic [rgbls_pkg::DataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == GapAddr) gap_cfg = data[rgbls_pkg::GapW-1:0];
    @(posedge clk_i);
  endtask

  task automatic check_gap_reg();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= GapAddr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[rgbls_pkg::GapW-1:0] !== gap_cfg) begin
      err_cnt++;
      $error("frame_gap_ticks: expected %0d, actual %0d", gap_cfg,
             prdata[rgbls_pkg::GapW-1:0]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_gap(input logic [rgbls_pkg::GapW-1:0] ticks);
    drain_results();
    write_reg(GapAddr, rgbls_pkg::DataW'(ticks));
    check_gap_reg();
  endtask

  // reset flush frame, ignored code, corner colors, writes mid-frame
  task automatic test_corners();
    check_gap_reg();
    write_reg(SpareAddr, '1);
    check_gap_reg();
    set_gap('0);
    send_item(FuncUnused, 2'd3, 2'd3, 8'hff, 8'hff, 8'hff);
    send_item(rgbls_pkg::FuncSetCell, 2'd0, 2'd0, 8'hff, 8'h00, 8'hff);
    send_item(rgbls_pkg::FuncSetCell, 2'd3, 2'd3, 8'h00, 8'hff, 8'h00);
    send_item(rgbls_pkg::FuncSetCell, 2'd0, 2'd3, 8'h80, 8'h01, 8'h7f);
    send_item(rgbls_pkg::FuncSetCell, 2'd3, 2'd0, 8'h01, 8'h80, 8'hfe);
    repeat (8) send_tick();
    send_item(rgbls_pkg::FuncClearAll, 2'd0, 2'd0, 8'h00, 8'h00, 8'h00);
    repeat (4) send_tick();
    send_item(rgbls_pkg::FuncSetCell, 2'd0, 2'd0, 8'h55, 8'haa, 8'hff);
    repeat (5) send_tick();
  endtask

  // gap 0 back to back, then a counting gap surviving a register change
  task automatic test_back_to_back_frames();
    int unsigned target;
    target = frames_sent + 2;
    while (frames_sent < target) begin
      fast_mode = ($urandom_range(0, 3) == 0);
      send_random(92);
    end
    fast_mode = 1'b0;
    set_gap(16'd5);
    target = frames_sent + 1;
    while (frames_sent < target) send_random(97);
    send_tick();
    send_tick();
    set_gap('0);
    target = frames_sent + 1;
    while (frames_sent < target) send_random(95);
  endtask

  task automatic test_max_gap();
    int unsigned target;
    set_gap('1);
    fast_mode = 1'b1;
    target = frames_sent + 1;
    while (frames_sent < target) send_random(98);
    send_item(rgbls_pkg::FuncSetCell, 2'd1, 2'd2, 8'h3c, 8'hc3, 8'h5a);
    repeat ((1 << rgbls_pkg::GapW) + 3) send_tick();
    fast_mode = 1'b0;
    set_gap(16'd1);
  endtask

  task automatic test_random_traffic();
    repeat (7) begin
      case ($urandom_range(0, 3))
        0: set_gap('0);
        1: set_gap(16'd1);
        2: set_gap(16'd2);
        default: set_gap(rgbls_pkg::GapW'($urandom_range(3, 40)));
      endcase
      fast_mode = ($urandom_range(0, 3) == 0);
      repeat (150) begin
        send_random(80);
        if ($urandom_range(0, 99) == 0) drain_results();
      end
      fast_mode = 1'b0;
    end
  endtask

  always @(posedge clk_i) begin
    serial_bit_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (bit_q.size() == 0) begin
        err_cnt++;
        $error("unexpected transfer: data_bit %0b frame_end %0b",
               res_if.data_bit, res_if.frame_end);
      end else begin
        want = bit_q.pop_front();
        if (res_if.data_bit !== want.data_bit) begin
          err_cnt++;
          $error("data_bit: expected %0b, actual %0b", want.data_bit, res_if.data_bit);
        end
        if (res_if.frame_end !== want.frame_end) begin
          err_cnt++;
          $error("frame_end: expected %0b, actual %0b", want.frame_end, res_if.frame_end);
        end
      end
    end
  end

  initial begin
    int unsigned stall;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = draw_idle();
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_if.valid) @(posedge clk_i);
    end
  end

  initial begin
    item_if.valid     <= 1'b0;
    item_if.func      <= '0;
    item_if.row_index <= '0;
    item_if.col_index <= '0;
    item_if.red       <= '0;
    item_if.green     <= '0;
    item_if.blue      <= '0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    rst_ni            <= 1'b0;
    foreach (pix_mem[i]) pix_mem[i] = '0;
    pending_frame = 1'b1;
    tx_active     = 1'b0;
    tx_cell       = '0;
    tx_copy       = '0;
    tx_bit        = '0;
    gap_left      = '0;
    gap_cfg       = rgbls_pkg::GapReset;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corners();
    test_back_to_back_frames();
    test_max_gap();
    test_random_traffic();

    drain_results();
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
